FILE: src/dsh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_pkg
// Shared codes, widths and helpers of the diamond-square heightmap block.
// ----------------------------------------------------------------------------
package dsh_pkg;

  // Request codes
  localparam logic [1:0] FUNC_START  = 2'd0;
  localparam logic [1:0] FUNC_SAMPLE = 2'd1;
  localparam logic [1:0] FUNC_READ   = 2'd2;
  localparam logic [1:0] FUNC_NONE   = 2'd3;

  // Result status codes
  localparam logic [1:0] STAT_ACCEPT = 2'd0;
  localparam logic [1:0] STAT_DONE   = 2'd1;
  localparam logic [1:0] STAT_READ   = 2'd2;
  localparam logic [1:0] STAT_REJECT = 2'd3;

  // Register indexes
  localparam logic [1:0] CFG_TERRAIN_SIZE  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT_REDUCE = 2'd1;
  localparam logic [1:0] CFG_MIN_HEIGHT    = 2'd2;
  localparam logic [1:0] CFG_MAX_HEIGHT    = 2'd3;

  // Displacement phases
  localparam logic [1:0] PH_DIAMOND = 2'd0;
  localparam logic [1:0] PH_LEFT    = 2'd1;
  localparam logic [1:0] PH_TOP     = 2'd2;

  // Register reset values
  localparam logic [8:0]         RST_TERRAIN_SIZE  = 9'd256;
  localparam logic [15:0]        RST_HEIGHT_REDUCE = 16'd32768;
  localparam logic signed [15:0] RST_MIN_HEIGHT    = 16'sd0;
  localparam logic signed [15:0] RST_MAX_HEIGHT    = 16'sd255;

  // Normalising divider widths
  localparam int DIVIDEND_W = 64;
  localparam int DIVISOR_W  = 32;
  localparam int QUOT_W     = 33;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
    if (v > 40'sh007FFFFFFF) begin
      return 32'sh7FFFFFFF;
    end else if (v < 40'shFF80000000) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

FILE: src/dsh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_if
// Request and result channels of the diamond-square heightmap block.
// ----------------------------------------------------------------------------
interface dsh_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic signed [15:0] random_sample;
  logic [7:0]         read_x;
  logic [7:0]         read_y;

  modport source (output valid, func, random_sample, read_x, read_y, input ready);
  modport sink   (input valid, func, random_sample, read_x, read_y, output ready);
endinterface

interface dsh_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic signed [31:0] height;

  modport source (output valid, status, height, input ready);
  modport sink   (input valid, status, height, output ready);
endinterface

FILE: src/dsh_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dsh_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module dsh_div (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  input  logic [dsh_pkg::DIVIDEND_W-1:0]   dividend,
  input  logic [dsh_pkg::DIVISOR_W-1:0]    divisor,
  output logic                             done,
  output logic [dsh_pkg::QUOT_W-1:0]       quotient
);

  localparam int NW = dsh_pkg::DIVIDEND_W;
  localparam int DW = dsh_pkg::DIVISOR_W;
  localparam int CNTW = $clog2(NW);

  logic [NW-1:0]   div_r, div_nxt;
  logic [DW-1:0]   rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;
  logic            busy_r, busy_nxt;
  logic            done_r, done_nxt;
  logic [DW:0]     trial;
  logic            ge;

  always_comb begin
    trial    = {rem_r, div_r[NW-1]};
    ge       = trial >= {1'b0, divisor};
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      div_nxt  = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = ge ? DW'(trial - {1'b0, divisor}) : trial[DW-1:0];
      div_nxt = {div_r[NW-2:0], ge};
      cnt_nxt = cnt_r + CNTW'(1);
      if (cnt_r == CNTW'(NW - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done     = done_r;
  assign quotient = div_r[dsh_pkg::QUOT_W-1:0];

endmodule

FILE: src/diamond_square_heightmap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_square_heightmap
// Wraparound diamond-square terrain generator with normalised read-back.
// ----------------------------------------------------------------------------
// Usage: send a start transaction (func 0) to clear the grid, then one random
// sample transaction (func 1) per displacement until a result with status 1
// (generation complete) comes back; read transactions (func 2) then return
// normalised heights. Every request yields exactly one result transaction.
// The four registers are written through cfg_we/cfg_addr/cfg_wdata; the user
// must do so only while idle, which the block itself does not enforce.
// Timing: one request at a time; in_ch.ready is high only when the sequencer
// is idle. A start sweeps the whole grid memory, one entry a cycle. A sample
// does four reads through the single read port, zero, one or two writes and
// uses the shared multiplier; a pass end adds an amplitude update, and the
// final sample adds a min/max scan. A read uses the bit-serial 64-step divider
// unless the grid is flat. Rejected requests go straight to the result push.
// Reset clears all control state and the registers; no clearing pass follows
// reset since the grid is unobservable until a start clears it.
// When the receiver stalls, the result is held in the output register and the
// sequencer waits with its next result until that one is taken.
// ----------------------------------------------------------------------------
module diamond_square_heightmap #(
  parameter int MAX_SIZE = 256
) (
  input  logic             clk,
  input  logic             rst_n,
  dsh_in_if.sink           in_ch,
  dsh_out_if.source        out_ch,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [15:0]      cfg_wdata
);

  localparam int CW    = (MAX_SIZE > 2) ? $clog2(MAX_SIZE) : 1;
  localparam int GW    = CW + 1;
  localparam int XW    = CW + 2;
  localparam int AW    = 2 * CW;
  localparam int DEPTH = 1 << AW;
  localparam int SW    = (GW > 9) ? GW : 9;
  localparam int RW    = (GW > 8) ? GW : 8;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_CLEAR  = 15'b000000000000010,
    S_DISP   = 15'b000000000000100,
    S_RD     = 15'b000000000001000,
    S_WR     = 15'b000000000010000,
    S_WR2    = 15'b000000000100000,
    S_ADV    = 15'b000000001000000,
    S_AMP    = 15'b000000010000000,
    S_AMPLD  = 15'b000000100000000,
    S_SCAN   = 15'b000001000000000,
    S_NRD    = 15'b000010000000000,
    S_NMUL   = 15'b000100000000000,
    S_NSTART = 15'b001000000000000,
    S_NDIV   = 15'b010000000000000,
    S_PUSH   = 15'b100000000000000
  } state_t;

  // Control state
  state_t             state_r, state_nxt;
  logic [8:0]         ts_r, ts_nxt;
  logic [15:0]        hr_r, hr_nxt;
  logic signed [15:0] minh_r, minh_nxt;
  logic signed [15:0] maxh_r, maxh_nxt;
  logic [GW-1:0]      gen_size_r, gen_size_nxt;
  logic [GW-1:0]      pass_r, pass_nxt;
  logic [1:0]         phase_r, phase_nxt;
  logic [CW-1:0]      cx_r, cx_nxt, cy_r, cy_nxt;
  logic [31:0]        amp_r, amp_nxt;
  logic signed [31:0] low_r, low_nxt, high_r, high_nxt;
  logic signed [31:0] pend_r, pend_nxt;
  logic               done_r, done_nxt;
  logic [2:0]         rd_cnt_r, rd_cnt_nxt;
  logic [AW-1:0]      clr_cnt_r, clr_cnt_nxt;
  logic [CW-1:0]      sx_r, sx_nxt, sy_r, sy_nxt;
  logic               scan_act_r, scan_act_nxt;
  logic               sv_r, sv_nxt;
  logic               first_r, first_nxt;
  logic               out_valid_r, out_valid_nxt;

  // Payload
  logic signed [15:0] samp_r, samp_nxt;
  logic signed [33:0] acc_r, acc_nxt;
  logic signed [51:0] mul_p_r;
  logic [CW-1:0]      rx_r, rx_nxt, ry_r, ry_nxt;
  logic [1:0]         res_status_r, res_status_nxt;
  logic signed [31:0] res_height_r, res_height_nxt;
  logic [1:0]         out_status_r;
  logic signed [31:0] out_height_r;

  // Grid memory
  logic signed [31:0] grid_mem [DEPTH];
  logic signed [31:0] rd_data_r;
  logic [AW-1:0]      raddr, waddr;
  logic signed [31:0] wdata;
  logic               mem_we;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      grid_mem[waddr] <= wdata;
    end
    rd_data_r <= grid_mem[raddr];
  end

  // Shared multiplier
  logic signed [33:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [51:0] mul_prod;
  logic               mul_en;

  // Normalisation
  logic signed [16:0] rng_w;
  logic [16:0]        absr;
  logic signed [32:0] dd_w, d_w;
  logic signed [34:0] base_w, nres_w;

  // Divider
  logic               div_start, div_done;
  logic [dsh_pkg::QUOT_W-1:0] quot;

  dsh_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend ({mul_p_r[47:0], 16'b0}),
    .divisor  (dd_w[31:0]),
    .done     (div_done),
    .quotient (quot)
  );

  function automatic logic [CW-1:0] mod_add(input logic [CW-1:0] a,
                                            input logic [GW-1:0] b,
                                            input logic [GW-1:0] n);
    logic [XW-1:0] t;
    t = XW'(a) + XW'(b);
    if (t >= XW'(n)) t = t - XW'(n);
    if (t >= XW'(n)) t = t - XW'(n);
    return t[CW-1:0];
  endfunction

  // Cell neighbourhood
  logic [GW-1:0]      half_w, nm1_full;
  logic [CW-1:0]      nm1, nx, ny, mx, my, pmx, pmy;
  logic [XW-1:0]      xs, ys;
  logic signed [39:0] sum_w;
  logic signed [31:0] newval;

  // Start decode
  logic [SW-1:0]      ts_e;
  logic [GW-1:0]      clamp_n, pow_n;
  logic [RW-1:0]      rdx_e, rdy_e;

  always_comb begin
    half_w   = pass_r >> 1;
    nm1_full = gen_size_r - GW'(1);
    nm1      = nm1_full[CW-1:0];
    nx = mod_add(cx_r, pass_r, gen_size_r);
    if (nx < cx_r) nx = nm1;
    ny = mod_add(cy_r, pass_r, gen_size_r);
    if (ny < cy_r) ny = nm1;
    mx  = mod_add(cx_r, half_w, gen_size_r);
    my  = mod_add(cy_r, half_w, gen_size_r);
    pmx = mod_add(cx_r, gen_size_r - half_w, gen_size_r);
    pmy = mod_add(cy_r, gen_size_r - half_w, gen_size_r);
    xs  = XW'(cx_r) + XW'(pass_r);
    ys  = XW'(cy_r) + XW'(pass_r);

    sum_w  = 40'(acc_r >>> 2) + 40'(mul_p_r >>> 15);
    newval = dsh_pkg::sat32(sum_w);

    rng_w  = 17'(maxh_r) - 17'(minh_r);
    absr   = rng_w[16] ? 17'(-rng_w) : rng_w;
    dd_w   = 33'(high_r) - 33'(low_r);
    d_w    = 33'(rd_data_r) - 33'(low_r);
    base_w = {{3{minh_r[15]}}, minh_r, 16'b0};
    nres_w = rng_w[16] ? base_w - 35'({2'b0, quot}) : base_w + 35'({2'b0, quot});

    ts_e = SW'(ts_r);
    if (ts_e < SW'(2)) begin
      clamp_n = GW'(2);
    end else if (ts_e > SW'(MAX_SIZE)) begin
      clamp_n = GW'(MAX_SIZE);
    end else begin
      clamp_n = ts_e[GW-1:0];
    end
    pow_n = GW'(1) << CW;
    for (int k = CW; k >= 0; k--) begin
      if ((GW'(1) << k) >= clamp_n) pow_n = GW'(1) << k;
    end
    rdx_e = RW'(in_ch.read_x);
    rdy_e = RW'(in_ch.read_y);
  end

  // Multiplier operand select
  always_comb begin
    mul_en = (state_r == S_DISP) || (state_r == S_AMP) || (state_r == S_NMUL);
    mul_a  = {2'b0, amp_r};
    mul_b  = {{2{samp_r[15]}}, samp_r};
    if (state_r == S_AMP) begin
      mul_b = {2'b0, hr_r};
    end else if (state_r == S_NMUL) begin
      mul_a = {2'b0, d_w[31:0]};
      mul_b = {1'b0, absr};
    end
    mul_prod = mul_a * mul_b;
  end

  // Read address
  always_comb begin
    raddr = {cy_r, cx_r};
    unique case (state_r)
      S_SCAN: raddr = {sy_r, sx_r};
      S_NRD:  raddr = {ry_r, rx_r};
      S_RD: begin
        priority case (rd_cnt_r)
          3'd1: raddr = (phase_r == dsh_pkg::PH_DIAMOND) ? {cy_r, nx} : {my, mx};
          3'd2: raddr = (phase_r == dsh_pkg::PH_TOP) ? {cy_r, nx} : {ny, cx_r};
          3'd3: begin
            if (phase_r == dsh_pkg::PH_DIAMOND) raddr = {ny, nx};
            else if (phase_r == dsh_pkg::PH_LEFT) raddr = {my, pmx};
            else raddr = {pmy, mx};
          end
          default: raddr = {cy_r, cx_r};
        endcase
      end
      default: raddr = {cy_r, cx_r};
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt      = state_r;
    ts_nxt         = ts_r;
    hr_nxt         = hr_r;
    minh_nxt       = minh_r;
    maxh_nxt       = maxh_r;
    gen_size_nxt   = gen_size_r;
    pass_nxt       = pass_r;
    phase_nxt      = phase_r;
    cx_nxt         = cx_r;
    cy_nxt         = cy_r;
    amp_nxt        = amp_r;
    low_nxt        = low_r;
    high_nxt       = high_r;
    pend_nxt       = pend_r;
    done_nxt       = done_r;
    rd_cnt_nxt     = rd_cnt_r;
    clr_cnt_nxt    = clr_cnt_r;
    sx_nxt         = sx_r;
    sy_nxt         = sy_r;
    scan_act_nxt   = scan_act_r;
    sv_nxt         = 1'b0;
    first_nxt      = first_r;
    out_valid_nxt  = out_valid_r;
    samp_nxt       = samp_r;
    acc_nxt        = acc_r;
    rx_nxt         = rx_r;
    ry_nxt         = ry_r;
    res_status_nxt = res_status_r;
    res_height_nxt = res_height_r;
    mem_we         = 1'b0;
    waddr          = {my, mx};
    wdata          = newval;
    div_start      = 1'b0;

    if (cfg_we) begin
      unique case (cfg_addr)
        dsh_pkg::CFG_TERRAIN_SIZE:  ts_nxt   = cfg_wdata[8:0];
        dsh_pkg::CFG_HEIGHT_REDUCE: hr_nxt   = cfg_wdata;
        dsh_pkg::CFG_MIN_HEIGHT:    minh_nxt = cfg_wdata;
        dsh_pkg::CFG_MAX_HEIGHT:    maxh_nxt = cfg_wdata;
        default: ;
      endcase
    end

    if (out_ch.ready) out_valid_nxt = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        res_height_nxt = '0;
        res_status_nxt = dsh_pkg::STAT_REJECT;
        if (in_ch.valid) begin
          state_nxt = S_PUSH;
          priority case (in_ch.func)
            dsh_pkg::FUNC_START: begin
              gen_size_nxt   = clamp_n;
              pass_nxt       = pow_n;
              amp_nxt        = 32'(pow_n >> 1) << 16;
              phase_nxt      = dsh_pkg::PH_DIAMOND;
              cx_nxt         = '0;
              cy_nxt         = '0;
              pend_nxt       = '0;
              low_nxt        = '0;
              high_nxt       = '0;
              done_nxt       = 1'b0;
              clr_cnt_nxt    = '0;
              res_status_nxt = dsh_pkg::STAT_ACCEPT;
              state_nxt      = S_CLEAR;
            end
            dsh_pkg::FUNC_SAMPLE: begin
              if (pass_r != '0) begin
                samp_nxt  = in_ch.random_sample;
                state_nxt = S_DISP;
              end
            end
            dsh_pkg::FUNC_READ: begin
              if (done_r && rdx_e < RW'(gen_size_r) && rdy_e < RW'(gen_size_r)) begin
                rx_nxt    = rdx_e[CW-1:0];
                ry_nxt    = rdy_e[CW-1:0];
                state_nxt = S_NRD;
              end
            end
            default: state_nxt = S_PUSH;
          endcase
        end
      end

      // Sweep the grid to zero
      S_CLEAR: begin
        mem_we      = 1'b1;
        waddr       = clr_cnt_r;
        wdata       = '0;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
        if (clr_cnt_r == {AW{1'b1}}) state_nxt = S_PUSH;
      end

      S_DISP: begin
        acc_nxt    = '0;
        rd_cnt_nxt = '0;
        state_nxt  = S_RD;
      end

      // Four corner reads, each accumulated in the cycle after its address is set
      S_RD: begin
        if (rd_cnt_r != 3'd0) acc_nxt = acc_r + 34'(rd_data_r);
        rd_cnt_nxt = rd_cnt_r + 3'd1;
        if (rd_cnt_r == 3'd4) state_nxt = S_WR;
      end

      S_WR: begin
        res_status_nxt = dsh_pkg::STAT_ACCEPT;
        if (phase_r == dsh_pkg::PH_DIAMOND) begin
          mem_we    = 1'b1;
          waddr     = {my, mx};
          state_nxt = S_ADV;
        end else if (phase_r == dsh_pkg::PH_LEFT) begin
          pend_nxt  = newval;
          phase_nxt = dsh_pkg::PH_TOP;
          state_nxt = S_PUSH;
        end else begin
          mem_we    = 1'b1;
          waddr     = {cy_r, mx};
          state_nxt = S_WR2;
        end
      end

      // Left edge lands last so it wins a shared point
      S_WR2: begin
        mem_we    = 1'b1;
        waddr     = {my, cx_r};
        wdata     = pend_r;
        state_nxt = S_ADV;
      end

      S_ADV: begin
        state_nxt = S_PUSH;
        if (xs < XW'(gen_size_r)) begin
          cx_nxt = xs[CW-1:0];
        end else begin
          cx_nxt = '0;
          if (ys < XW'(gen_size_r)) begin
            cy_nxt = ys[CW-1:0];
          end else begin
            cy_nxt = '0;
            if (phase_r == dsh_pkg::PH_DIAMOND) begin
              phase_nxt = dsh_pkg::PH_LEFT;
            end else begin
              phase_nxt = dsh_pkg::PH_DIAMOND;
              pass_nxt  = pass_r >> 1;
              state_nxt = S_AMP;
            end
          end
        end
        if (phase_r == dsh_pkg::PH_TOP && state_nxt == S_PUSH) begin
          phase_nxt = dsh_pkg::PH_LEFT;
        end
      end

      S_AMP: state_nxt = S_AMPLD;

      S_AMPLD: begin
        amp_nxt = mul_p_r[47:16];
        if (pass_r == '0) begin
          sx_nxt       = '0;
          sy_nxt       = '0;
          scan_act_nxt = 1'b1;
          first_nxt    = 1'b1;
          state_nxt    = S_SCAN;
        end else begin
          state_nxt = S_PUSH;
        end
      end

      // Min/max over the generated square, one point a cycle
      S_SCAN: begin
        sv_nxt = scan_act_r;
        if (scan_act_r) begin
          if (sx_r == nm1) begin
            sx_nxt = '0;
            if (sy_r == nm1) scan_act_nxt = 1'b0;
            else sy_nxt = sy_r + CW'(1);
          end else begin
            sx_nxt = sx_r + CW'(1);
          end
        end
        if (sv_r) begin
          first_nxt = 1'b0;
          if (first_r) begin
            low_nxt  = rd_data_r;
            high_nxt = rd_data_r;
          end else begin
            if (rd_data_r < low_r) low_nxt = rd_data_r;
            if (rd_data_r > high_r) high_nxt = rd_data_r;
          end
        end
        if (!scan_act_r && !sv_r) begin
          done_nxt       = 1'b1;
          phase_nxt      = dsh_pkg::PH_DIAMOND;
          res_status_nxt = dsh_pkg::STAT_DONE;
          state_nxt      = S_PUSH;
        end
      end

      S_NRD: state_nxt = S_NMUL;

      S_NMUL: begin
        res_status_nxt = dsh_pkg::STAT_READ;
        if (dd_w == '0) begin
          res_height_nxt = base_w[31:0];
          state_nxt      = S_PUSH;
        end else begin
          state_nxt = S_NSTART;
        end
      end

      S_NSTART: begin
        div_start = 1'b1;
        state_nxt = S_NDIV;
      end

      S_NDIV: begin
        if (div_done) begin
          res_height_nxt = dsh_pkg::sat32(40'(nres_w));
          state_nxt      = S_PUSH;
        end
      end

      // Hand the result to the output register once it is free
      S_PUSH: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ts_r        <= dsh_pkg::RST_TERRAIN_SIZE;
      hr_r        <= dsh_pkg::RST_HEIGHT_REDUCE;
      minh_r      <= dsh_pkg::RST_MIN_HEIGHT;
      maxh_r      <= dsh_pkg::RST_MAX_HEIGHT;
      gen_size_r  <= GW'(2);
      pass_r      <= '0;
      phase_r     <= dsh_pkg::PH_DIAMOND;
      cx_r        <= '0;
      cy_r        <= '0;
      amp_r       <= '0;
      low_r       <= '0;
      high_r      <= '0;
      pend_r      <= '0;
      done_r      <= 1'b0;
      rd_cnt_r    <= '0;
      clr_cnt_r   <= '0;
      sx_r        <= '0;
      sy_r        <= '0;
      scan_act_r  <= 1'b0;
      sv_r        <= 1'b0;
      first_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ts_r        <= ts_nxt;
      hr_r        <= hr_nxt;
      minh_r      <= minh_nxt;
      maxh_r      <= maxh_nxt;
      gen_size_r  <= gen_size_nxt;
      pass_r      <= pass_nxt;
      phase_r     <= phase_nxt;
      cx_r        <= cx_nxt;
      cy_r        <= cy_nxt;
      amp_r       <= amp_nxt;
      low_r       <= low_nxt;
      high_r      <= high_nxt;
      pend_r      <= pend_nxt;
      done_r      <= done_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      sx_r        <= sx_nxt;
      sy_r        <= sy_nxt;
      scan_act_r  <= scan_act_nxt;
      sv_r        <= sv_nxt;
      first_r     <= first_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    samp_r       <= samp_nxt;
    acc_r        <= acc_nxt;
    rx_r         <= rx_nxt;
    ry_r         <= ry_nxt;
    res_status_r <= res_status_nxt;
    res_height_r <= res_height_nxt;
    if (mul_en) mul_p_r <= mul_prod;
    if (state_r == S_PUSH && (!out_valid_r || out_ch.ready)) begin
      out_status_r <= res_status_r;
      out_height_r <= res_height_r;
    end
  end

  assign in_ch.ready   = (state_r == S_IDLE);
  assign out_ch.valid  = out_valid_r;
  assign out_ch.status = out_status_r;
  assign out_ch.height = out_height_r;

  // Extremes are ordered once generation has completed
  a_extremes_ordered: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (low_r <= high_r))
    else $error("grid extremes out of order");

  // The walking cell stays inside the generated square
  a_cell_in_grid: assert property (@(posedge clk) disable iff (!rst_n)
    (pass_r != '0) |-> (GW'(cx_r) < gen_size_r && GW'(cy_r) < gen_size_r))
    else $error("cell corner outside grid");

  // Completion only follows the last pass
  a_done_after_last_pass: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_r) |-> (pass_r == '0 && phase_r == dsh_pkg::PH_DIAMOND))
    else $error("completion flagged with passes left");

  // A finished grid is never written
  a_no_write_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> !done_r)
    else $error("grid written after completion");

endmodule
